FILE: rtl/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg: shared types and decode functions for the hex text parser
// Character constants, parse modes, controller commands, status bundle and
// the single-character parse step used by the datapath.
// ----------------------------------------------------------------------------
package htb_pkg;

  // Offset prefix buffer depth (hex digits held at line start)
  localparam int PREFIX_DEPTH = 16;
  localparam int CNT_W        = $clog2(PREFIX_DEPTH + 1);
  localparam int IDX_W        = $clog2(PREFIX_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_ERROR = CFG_IDX_W'(1);

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NIBBLE  = 3'd1,
    ERR_ESCAPE  = 3'd2,
    ERR_UNTERM  = 3'd3,
    ERR_INVALID = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    M_PREFIX = 3'd0,
    M_COLON  = 3'd1,
    M_DATA   = 3'd2,
    M_NIBBLE = 3'd3,
    M_STRING = 3'd4,
    M_ESCAPE = 3'd5,
    M_SKIP   = 3'd6
  } mode_t;

  // Classification of the incoming character against the line-start state
  typedef enum logic [2:0] {
    CLS_STORE,        // hex digit goes into the prefix buffer
    CLS_TO_COLON,     // colon after prefix digits
    CLS_OFFSET,       // colon and space: prefix was an offset
    CLS_DIRECT,       // parsed in one step, no flush
    CLS_FLUSH,        // flush held digits, then parse the character
    CLS_FLUSH_COLON   // flush, parse the colon, then parse the character
  } cls_t;

  // Controller commands to the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_TO_COLON,
    OP_OFFSET,
    OP_DIRECT,
    OP_CAPTURE,
    OP_FLUSH_PAIR,
    OP_FLUSH_END,
    OP_STEP_COLON,
    OP_STEP_CHAR
  } op_t;

  typedef struct packed {
    cls_t cls;
    logic pair_avail;   // at least two digits left in the buffer
    logic colon_case;   // captured character follows a colon
    logic out_free;     // output register can take a result this cycle
  } status_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] pend;
    logic       emit;
    logic [7:0] data;
    logic       valid;
    err_t       err;
  } step_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if ((c >= CH_0) && (c <= CH_9)) t = c - CH_0;
    else if ((c >= CH_LA) && (c <= CH_LF)) t = c - (CH_LA - 8'd10);
    else if ((c >= CH_UA) && (c <= CH_UF)) t = c - (CH_UA - 8'd10);
    else t = 8'h00;
    return t[3:0];
  endfunction

  // One character of data/string parsing from a given mode
  function automatic step_t htb_step(input mode_t mode, input logic [3:0] pend,
                                     input logic [7:0] c, input logic str_en,
                                     input logic stop);
    step_t s;
    s.mode  = mode;
    s.pend  = pend;
    s.emit  = 1'b0;
    s.data  = 8'h00;
    s.valid = 1'b0;
    s.err   = ERR_NONE;
    unique case (mode)
      M_DATA: begin
        if (c == CH_NL) begin
          s.mode = M_PREFIX;
          s.pend = 4'h0;
        end else if ((c == CH_BAR) || (c == CH_SEMI) || (c == CH_CR) || (c == CH_NUL)) begin
          s.mode = M_SKIP;
        end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)) begin
          s.mode = M_DATA;
        end else if (is_hex(c)) begin
          s.pend = hex_val(c);
          s.mode = M_NIBBLE;
        end else if ((c == CH_QUOTE) && str_en) begin
          s.mode = M_STRING;
        end else begin
          s.emit = 1'b1;
          s.err  = ERR_INVALID;
          if (stop) s.mode = M_SKIP;
        end
      end
      M_NIBBLE: begin
        s.emit = 1'b1;
        s.pend = 4'h0;
        if (is_hex(c)) begin
          s.data  = {pend, hex_val(c)};
          s.valid = 1'b1;
          s.mode  = M_DATA;
        end else begin
          s.err = ERR_NIBBLE;
          if (c == CH_NL) s.mode = M_PREFIX;
          else if ((c == CH_NUL) || stop) s.mode = M_SKIP;
          else s.mode = M_DATA;
        end
      end
      M_STRING, M_ESCAPE: begin
        if (c == CH_NL) begin
          s.emit = 1'b1;
          s.err  = ERR_UNTERM;
          s.mode = M_PREFIX;
          s.pend = 4'h0;
        end else if ((c == CH_CR) || (c == CH_NUL)) begin
          s.emit = 1'b1;
          s.err  = ERR_UNTERM;
          s.mode = M_SKIP;
        end else if (mode == M_STRING) begin
          if (c == CH_BSLASH) s.mode = M_ESCAPE;
          else if (c == CH_QUOTE) s.mode = M_DATA;
          else begin
            s.emit  = 1'b1;
            s.data  = c;
            s.valid = 1'b1;
          end
        end else begin
          // escape sequence
          s.mode  = M_STRING;
          s.emit  = 1'b1;
          s.valid = 1'b1;
          unique case (c)
            CH_LN:     s.data = CH_NL;
            CH_LR:     s.data = CH_CR;
            CH_LT:     s.data = CH_TAB;
            CH_LV:     s.data = CH_VT;
            CH_LA:     s.data = CH_BEL;
            CH_LB:     s.data = CH_BS;
            CH_LF:     s.data = CH_FF;
            CH_QUOTE:  s.data = CH_QUOTE;
            CH_BSLASH: s.data = CH_BSLASH;
            default: begin
              s.data = c;
              s.err  = ERR_ESCAPE;
            end
          endcase
        end
      end
      default: begin
        // skip to end of line
        if (c == CH_NL) begin
          s.mode = M_PREFIX;
          s.pend = 4'h0;
        end else begin
          s.mode = M_SKIP;
        end
      end
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/htb_in_if.sv
// ----------------------------------------------------------------------------
// htb_in_if: character input channel
// Valid/ready channel carrying one text character per beat.
// ----------------------------------------------------------------------------
interface htb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

FILE: rtl/htb_out_if.sv
// ----------------------------------------------------------------------------
// htb_out_if: decoded result channel
// Valid/ready channel carrying one decoded byte or error report per beat.
// ----------------------------------------------------------------------------
interface htb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input error_code,
                  input last, output ready);
endinterface

FILE: rtl/htb_cfg_if.sv
// ----------------------------------------------------------------------------
// htb_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface htb_cfg_if;
  import htb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/htb_ctrl.sv
// ----------------------------------------------------------------------------
// htb_ctrl: parser sequencer
// Accepts characters and sequences prefix flushes and multi-step parsing.
// ----------------------------------------------------------------------------
module htb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  htb_pkg::status_t status,
  output htb_pkg::op_t     op
);
  import htb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_COLON,
    S_CHAR
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Command decode and next state
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          unique case (status.cls)
            CLS_STORE:    op = OP_STORE;
            CLS_TO_COLON: op = OP_TO_COLON;
            CLS_OFFSET:   op = OP_OFFSET;
            CLS_DIRECT:   op = OP_DIRECT;
            default: begin
              op        = OP_CAPTURE;
              state_nxt = S_FLUSH;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (status.pair_avail) begin
          if (status.out_free) op = OP_FLUSH_PAIR;
        end else begin
          op        = OP_FLUSH_END;
          state_nxt = status.colon_case ? S_COLON : S_CHAR;
        end
      end
      S_COLON: begin
        if (status.out_free) begin
          op        = OP_STEP_COLON;
          state_nxt = S_CHAR;
        end
      end
      default: begin
        if (status.out_free) begin
          op        = OP_STEP_CHAR;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/htb_dpath.sv
// ----------------------------------------------------------------------------
// htb_dpath: parser datapath
// Parse state, prefix digit buffer, config registers and output register.
// ----------------------------------------------------------------------------
module htb_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    in_char,
  input  logic                          cfg_valid,
  input  logic [htb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic [2:0]                    error_code,
  output logic                          last,
  input  htb_pkg::op_t                  op,
  output htb_pkg::status_t              status
);
  import htb_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [3:0]       pend_r, pend_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       dig_r [PREFIX_DEPTH];
  logic [7:0]       char_r;
  logic             colon_r;
  logic             str_en_r;
  logic             stop_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             byte_valid_r;
  err_t             err_r;
  logic             last_r;

  mode_t            s1_mode;
  logic [3:0]       s1_pend;
  logic [7:0]       s1_char;
  mode_t            s2_mode;
  logic [3:0]       s2_pend;
  step_t            s1;
  step_t            s2;
  logic             out_free;
  logic             emit_go;
  logic             tail_emits;
  logic             res_last;
  logic [7:0]       res_byte;
  logic             res_valid;
  err_t             res_err;
  cls_t             cls;

  assign out_free = !out_valid_r || out_ready;

  // Classify the character waiting at the input
  always_comb begin
    unique case (mode_r)
      M_PREFIX: begin
        if (is_hex(in_char) && (count_r < CNT_W'(PREFIX_DEPTH))) cls = CLS_STORE;
        else if (in_char == CH_COLON) cls = CLS_TO_COLON;
        else if (count_r == '0) cls = CLS_DIRECT;
        else cls = CLS_FLUSH;
      end
      M_COLON: cls = (in_char == CH_SPACE) ? CLS_OFFSET : CLS_FLUSH_COLON;
      default: cls = CLS_DIRECT;
    endcase
  end

  assign status.cls        = cls;
  assign status.pair_avail = (count_r >= CNT_W'(2));
  assign status.colon_case = colon_r;
  assign status.out_free   = out_free;

  // Main step input select; an empty prefix parses as data
  always_comb begin
    s1_pend = pend_r;
    unique case (op)
      OP_DIRECT: begin
        s1_mode = (mode_r == M_PREFIX) ? M_DATA : mode_r;
        s1_char = in_char;
      end
      OP_STEP_COLON: begin
        s1_mode = mode_r;
        s1_char = CH_COLON;
      end
      default: begin
        s1_mode = mode_r;
        s1_char = char_r;
      end
    endcase
  end

  assign s1 = htb_step(s1_mode, s1_pend, s1_char, str_en_r, stop_r);

  // Lookahead step: the character after the colon, or the tail after a flush
  always_comb begin
    if (op == OP_STEP_COLON) begin
      s2_mode = s1.mode;
      s2_pend = s1.pend;
    end else begin
      s2_mode = M_DATA;
      s2_pend = 4'h0;
    end
  end

  assign s2 = htb_step(s2_mode, s2_pend, char_r, str_en_r, stop_r);

  // Odd digit count or a colon step always yields a result after the flush
  assign tail_emits = colon_r || count_r[0] || s2.emit;

  // Result select
  always_comb begin
    emit_go   = 1'b0;
    res_byte  = s1.data;
    res_valid = s1.valid;
    res_err   = s1.err;
    res_last  = 1'b1;
    unique case (op)
      OP_DIRECT, OP_STEP_CHAR: emit_go = s1.emit;
      OP_STEP_COLON: begin
        emit_go  = s1.emit;
        res_last = !s2.emit;
      end
      OP_FLUSH_PAIR: begin
        emit_go   = 1'b1;
        res_byte  = {dig_r[0], dig_r[1]};
        res_valid = 1'b1;
        res_err   = ERR_NONE;
        res_last  = (count_r < CNT_W'(4)) && !tail_emits;
      end
      default: emit_go = 1'b0;
    endcase
  end

  // Parse state next values
  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    count_nxt = count_r;
    unique case (op)
      OP_STORE:      count_nxt = count_r + CNT_W'(1);
      OP_TO_COLON:   mode_nxt = M_COLON;
      OP_OFFSET: begin
        mode_nxt  = M_DATA;
        count_nxt = '0;
      end
      OP_DIRECT, OP_STEP_COLON, OP_STEP_CHAR: begin
        mode_nxt = s1.mode;
        pend_nxt = s1.pend;
      end
      OP_FLUSH_PAIR: count_nxt = count_r - CNT_W'(2);
      OP_FLUSH_END: begin
        mode_nxt  = count_r[0] ? M_NIBBLE : M_DATA;
        pend_nxt  = count_r[0] ? dig_r[0] : 4'h0;
        count_nxt = '0;
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // Output register handshake
  always_comb begin
    if (emit_go) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_PREFIX;
      pend_r      <= 4'h0;
      count_r     <= '0;
      colon_r     <= 1'b0;
      str_en_r    <= 1'b1;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (op == OP_CAPTURE) colon_r <= (cls == CLS_FLUSH_COLON);
      if (cfg_valid && (cfg_index == CFG_STRING_ENABLE)) str_en_r <= cfg_data;
      if (cfg_valid && (cfg_index == CFG_STOP_ON_ERROR)) stop_r <= cfg_data;
    end
  end

  // Prefix buffer: written at the fill position, drained two digits at a time
  always_ff @(posedge clk) begin
    if (op == OP_STORE) begin
      dig_r[count_r[IDX_W-1:0]] <= hex_val(in_char);
    end else if (op == OP_FLUSH_PAIR) begin
      for (int i = 0; i < PREFIX_DEPTH - 2; i++) begin
        dig_r[i] <= dig_r[i+2];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (op == OP_CAPTURE) char_r <= in_char;
    if (emit_go) begin
      out_byte_r   <= res_byte;
      byte_valid_r <= res_valid;
      err_r        <= res_err;
      last_r       <= res_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign byte_valid = byte_valid_r;
  assign error_code = err_r;
  assign last       = last_r;

endmodule

FILE: rtl/hex_text_to_bytes_parser_unit.sv
// ----------------------------------------------------------------------------
// hex_text_to_bytes_parser_unit: hex dump text to byte decoder
// Decodes a character stream of hex dump text into bytes and error reports.
// ----------------------------------------------------------------------------
// When the controller is idle, a character is accepted whenever the output
// register is empty or being drained; most characters are parsed as they are
// accepted and yield at most one result. Hex digits at the start of a line
// are held in a 16-digit prefix buffer. A character that releases them as
// data is captured, the held digits drain as bytes a pair at a time through
// the single output register, the flush is closed, a lone colon that preceded
// it is parsed, and then the character itself is parsed. Results carry last
// on the final result of each character. Configuration writes are always
// accepted and take effect on the next cycle.
module hex_text_to_bytes_parser_unit (
  input  logic      clk,
  input  logic      rst_n,
  htb_in_if.sink    in_ch,
  htb_out_if.source out_ch,
  htb_cfg_if.sink   cfg_ch
);
  import htb_pkg::*;

  op_t     op;
  status_t status;

  // Configuration writes never stall
  assign cfg_ch.ready = 1'b1;

  htb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .op       (op)
  );

  htb_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_ch.in_char),
    .cfg_valid  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .error_code (out_ch.error_code),
    .last       (out_ch.last),
    .op         (op),
    .status     (status)
  );

endmodule
